>>> sv/smx_pkg.sv
// Package for the stack machine executor.
// Holds sizes, opcode, status, output kind and syscall codes, and the queue entry type.
// No dependencies.
package smx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam int WORD_W   = 64;
  localparam int OPC_W    = 3;
  localparam int IMM_W    = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CHAR_W   = 8;

  localparam logic [OPC_W-1:0] OPC_HALT    = 3'd0;
  localparam logic [OPC_W-1:0] OPC_PUSH    = 3'd1;
  localparam logic [OPC_W-1:0] OPC_POP     = 3'd2;
  localparam logic [OPC_W-1:0] OPC_ADD     = 3'd3;
  localparam logic [OPC_W-1:0] OPC_SYSCALL = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd2;

  localparam logic [CHAR_W-1:0] SYS_WR_INT  = 8'd0;
  localparam logic [CHAR_W-1:0] SYS_WR_CHAR = 8'd1;
  localparam logic [CHAR_W-1:0] SYS_RD_INT  = 8'd3;
  localparam logic [CHAR_W-1:0] SYS_RD_CHAR = 8'd4;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_HALT,
    CLS_PUSH,
    CLS_POP,
    CLS_ADD,
    CLS_SYS
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [IMM_W-1:0]  imm;
    logic [WORD_W-1:0] rd;
  } q_entry_t;

endpackage

>>> sv/smx_if.sv
// Channel interfaces of the stack machine executor: instruction input and result output.
// Depends on smx_pkg for field widths.
interface smx_in_if import smx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [IMM_W-1:0]         immediate;
  logic signed [WORD_W-1:0] read_value;

  modport source (output valid, opcode, immediate, read_value, input ready);
  modport sink   (input valid, opcode, immediate, read_value, output ready);
endinterface

interface smx_out_if import smx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        out_kind;
  logic signed [WORD_W-1:0] out_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, out_kind, out_value, status, input ready);
  modport sink   (input valid, out_kind, out_value, status, output ready);
endinterface

>>> sv/smx_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module smx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/smx_front.sv
// Front part: accepts instruction transactions, classifies the opcode and queues them.
// Depends on smx_pkg and smx_in_if.
module smx_front import smx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  smx_in_if.sink   in_ch,
  output logic     q_valid,
  output q_entry_t q_head,
  input  logic     q_pop
);

  q_entry_t            q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push;
  q_entry_t            entry;

  always_comb begin
    case (in_ch.opcode)
      OPC_HALT:    entry.cls = CLS_HALT;
      OPC_PUSH:    entry.cls = CLS_PUSH;
      OPC_POP:     entry.cls = CLS_POP;
      OPC_ADD:     entry.cls = CLS_ADD;
      OPC_SYSCALL: entry.cls = CLS_SYS;
      default:     entry.cls = CLS_NOP;
    endcase
    entry.imm = in_ch.immediate;
    entry.rd  = in_ch.read_value;
  end

  assign in_ch.ready = (cnt_r < QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_head      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count beyond depth");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> (cnt_r == $past(cnt_r) + QCNT_W'(1)))
    else $error("queue count did not follow a push");
`endif

endmodule

>>> sv/smx_back.sv
// Back part: executes queued instructions against the stack and holds the result register.
// The top two entries live in registers, the rest in an smx_ram; depends on smx_pkg, smx_out_if.
module smx_back import smx_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  smx_out_if.source out_ch
);

  logic [SP_W-1:0]     sp_r, sp_nxt;
  logic                stopped_r, stopped_nxt;
  logic                refill_r, refill_nxt;
  logic [WORD_W-1:0]   top_r, top_nxt;
  logic [WORD_W-1:0]   sec_r, sec_nxt;
  logic                byp_vld_r;
  logic [WORD_W-1:0]   byp_data_r;

  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [WORD_W-1:0]   out_value_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [KIND_W-1:0]   res_kind;
  logic [WORD_W-1:0]   res_value;
  logic [STATUS_W-1:0] res_status;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [WORD_W-1:0]   third;
  logic [SP_W-1:0]     sp_p1, sp_m1, sp_m2, sp_m3, sp_m4;
  logic [CHAR_W-1:0]   sel;
  logic                go;

  smx_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Outside a refill, the RAM read port holds the entry just below the cached pair.
  // A write to the address being read in the same cycle is forwarded.
  assign third = byp_vld_r ? byp_data_r : ram_rdata;

  assign sp_p1 = sp_r + SP_W'(1);
  assign sp_m1 = sp_r - SP_W'(1);
  assign sp_m2 = sp_r - SP_W'(2);
  assign sp_m3 = sp_r - SP_W'(3);
  assign sp_m4 = sp_r - SP_W'(4);
  assign sel   = top_r[CHAR_W-1:0];

  assign go    = q_valid && !refill_r && (!out_valid_r || out_ch.ready);
  assign q_pop = go;

  always_comb begin
    sp_nxt      = sp_r;
    top_nxt     = top_r;
    sec_nxt     = sec_r;
    stopped_nxt = stopped_r;
    refill_nxt  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = sp_m2[ADDR_W-1:0];
    ram_wdata   = sec_r;
    ram_raddr   = sp_m3[ADDR_W-1:0];
    res_kind    = KIND_NONE;
    res_value   = '0;
    res_status  = ST_OK;
    if (refill_r) begin
      // Refill after a write syscall: the new second entry arrives from the RAM.
      sec_nxt = third;
    end else if (go) begin
      if (stopped_r) begin
        res_status = ST_STOPPED;
      end else begin
        case (q_head.cls)
          CLS_HALT: begin
            res_status = ST_STOPPED;
          end
          CLS_PUSH: begin
            if (sp_r >= SP_W'(STACK_DEPTH)) begin
              res_status = ST_OVERFLOW;
            end else begin
              ram_we    = (sp_r >= SP_W'(2));
              top_nxt   = {{(WORD_W-IMM_W){1'b0}}, q_head.imm};
              sec_nxt   = top_r;
              sp_nxt    = sp_p1;
              ram_raddr = sp_m2[ADDR_W-1:0];
            end
          end
          CLS_POP: begin
            if (sp_r == '0) begin
              res_status = ST_UNDERFLOW;
            end else begin
              top_nxt   = sec_r;
              sec_nxt   = third;
              sp_nxt    = sp_m1;
              ram_raddr = sp_m4[ADDR_W-1:0];
            end
          end
          CLS_ADD: begin
            if (sp_r < SP_W'(2)) begin
              res_status = ST_UNDERFLOW;
            end else begin
              top_nxt   = sec_r + top_r;
              sec_nxt   = third;
              sp_nxt    = sp_m1;
              ram_raddr = sp_m4[ADDR_W-1:0];
            end
          end
          CLS_SYS: begin
            if (sp_r == '0) begin
              res_status = ST_UNDERFLOW;
            end else if ((sel == SYS_WR_INT || sel == SYS_WR_CHAR) && sp_r < SP_W'(2)) begin
              res_status = ST_UNDERFLOW;
            end else begin
              case (sel)
                SYS_WR_INT, SYS_WR_CHAR: begin
                  if (sel == SYS_WR_INT) begin
                    res_kind  = KIND_INT;
                    res_value = sec_r;
                  end else begin
                    res_kind  = KIND_CHAR;
                    res_value = {{(WORD_W-CHAR_W){1'b0}}, sec_r[CHAR_W-1:0]};
                  end
                  top_nxt    = third;
                  sp_nxt     = sp_m2;
                  ram_raddr  = sp_m4[ADDR_W-1:0];
                  refill_nxt = 1'b1;
                end
                SYS_RD_INT: begin
                  top_nxt = q_head.rd;
                end
                SYS_RD_CHAR: begin
                  top_nxt = {{(WORD_W-CHAR_W){1'b0}}, q_head.rd[CHAR_W-1:0]};
                end
                default: begin
                  res_status = ST_UNKNOWN;
                end
              endcase
            end
          end
          default: begin
            res_status = ST_OK;
          end
        endcase
      end
      if (res_status != ST_OK) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      stopped_r   <= 1'b0;
      refill_r    <= 1'b0;
      byp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sp_r      <= sp_nxt;
      stopped_r <= stopped_nxt;
      refill_r  <= refill_nxt;
      byp_vld_r <= ram_we && (ram_waddr == ram_raddr);
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    sec_r      <= sec_nxt;
    byp_data_r <= ram_wdata;
    if (go) begin
      out_kind_r   <= res_kind;
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_kind  = out_kind_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = out_status_r;

`ifndef SYNTHESIS
  a_stopped_sp: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> $stable(sp_r)) else $error("stack pointer moved while stopped");
  a_refill_one: assert property (@(posedge clk) disable iff (!rst_n)
    refill_r |=> !refill_r) else $error("refill lasted more than one cycle");
  a_refill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    refill_r |-> !q_pop) else $error("instruction taken during refill");
  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res_status != ST_OK) |=> stopped_r) else $error("error did not stop machine");
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH)) else $error("stack pointer beyond depth");
`endif

endmodule

>>> sv/stack_machine_executor_unit.sv
// Stack machine executor: one instruction per transaction in, one result per transaction out.
// An accepted instruction is queued in the front part, and the back part registers its result
// in the output register when it takes the instruction from the queue.
// Throughput: one instruction per cycle while results are taken; a write syscall holds the back
// part while the cached second stack entry is reloaded through the RAM's registered read port.
// Reset: synchronous, active low; clears the stack pointer, the stop flag and the queue.
// Stack RAM contents are not cleared; unwritten entries may be read but never become live entries.
module stack_machine_executor_unit import smx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  smx_in_if.sink    in_ch,
  smx_out_if.source out_ch
);

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_head;

  smx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  smx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the stack machine executor: a table of directed instructions,
// then random well-formed programs checked against an in-bench copy of the machine.
// Depends on smx_pkg, the smx_in_if/smx_out_if interfaces and stack_machine_executor_unit.
module testbench import smx_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int STOPPED_ITEMS = 12;

  // Opcodes without a meaning; the machine treats them as no-ops.
  localparam logic [OPC_W-1:0] OPC_RSVD5 = 3'd5;
  localparam logic [OPC_W-1:0] OPC_RSVD6 = 3'd6;
  localparam logic [OPC_W-1:0] OPC_RSVD7 = 3'd7;

  localparam logic [WORD_W-1:0] W_ZERO = '0;
  localparam logic [WORD_W-1:0] W_ONES = '1;
  localparam logic [WORD_W-1:0] W_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] W_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WORD_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct {
    logic [OPC_W-1:0]  op;
    logic [IMM_W-1:0]  imm;
    logic [WORD_W-1:0] rd;
    bit                from_table;
    result_t           res;
  } dir_row_t;

  typedef enum int {END_HALT, END_OVERFLOW, END_UNDERFLOW, END_UNKNOWN} end_kind_t;

  localparam result_t R_OK       = '{KIND_NONE, W_ZERO, ST_OK};
  localparam bit      FROM_TABLE = 1'b1;
  localparam bit      FROM_MODEL = 1'b0;
  localparam int      DIR_ROWS   = 26;

  // The stack is built up and emptied through every syscall, with the word extremes
  // passing through read, add and write.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OPC_PUSH,    8'hFF,       W_ZERO, FROM_TABLE, R_OK},
    '{OPC_PUSH,    8'h00,       W_ONES, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'hAA,       W_ZERO, FROM_TABLE, '{KIND_INT, 64'd255, ST_OK}},
    '{OPC_RSVD5,   8'h00,       W_MIN,  FROM_TABLE, R_OK},
    '{OPC_RSVD6,   8'hFF,       W_MAX,  FROM_TABLE, R_OK},
    '{OPC_RSVD7,   8'h55,       W_ONES, FROM_TABLE, R_OK},
    '{OPC_PUSH,    8'h41,       W_ZERO, FROM_TABLE, R_OK},
    '{OPC_PUSH,    SYS_WR_CHAR, W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_ONES, FROM_TABLE, '{KIND_CHAR, 64'h41, ST_OK}},
    '{OPC_PUSH,    SYS_RD_INT,  W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_MIN,  FROM_TABLE, R_OK},
    '{OPC_PUSH,    SYS_WR_INT,  W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_ZERO, FROM_TABLE, '{KIND_INT, W_MIN, ST_OK}},
    '{OPC_PUSH,    SYS_RD_INT,  W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_MAX,  FROM_TABLE, R_OK},
    '{OPC_PUSH,    SYS_RD_INT,  W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_ONES, FROM_TABLE, R_OK},
    '{OPC_ADD,     8'h00,       W_ZERO, FROM_TABLE, R_OK},
    '{OPC_PUSH,    SYS_WR_INT,  W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_ZERO, FROM_MODEL, R_OK},
    '{OPC_PUSH,    SYS_RD_CHAR, W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       64'hFFFF_FFFF_FFFF_FF80, FROM_TABLE, R_OK},
    '{OPC_PUSH,    SYS_WR_CHAR, W_ZERO, FROM_TABLE, R_OK},
    '{OPC_SYSCALL, 8'h00,       W_ZERO, FROM_MODEL, R_OK},
    '{OPC_PUSH,    8'h7F,       W_ZERO, FROM_TABLE, R_OK},
    '{OPC_POP,     8'h80,       W_ZERO, FROM_TABLE, R_OK}
  };

  logic clk;
  logic rst_n;

  smx_in_if  in_ch ();
  smx_out_if out_ch ();

  stack_machine_executor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow machine state, advanced once per accepted instruction.
  logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
  int                stk_ptr = 0;
  bit                halted  = 1'b0;
  bit                climbing = 1'b1;

  result_t awaited_results [$];
  int      fail_count   = 0;
  int      cycle_count  = 0;
  int      tx_idle_pct  = 16;
  int      rx_idle_pct  = 87;
  bit      hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t exec_instr(input logic [OPC_W-1:0] op,
                                         input logic [IMM_W-1:0] imm,
                                         input logic [WORD_W-1:0] rd);
    result_t           r;
    logic [CHAR_W-1:0] sel;
    r = R_OK;
    if (halted) begin
      r.status = ST_STOPPED;
    end else begin
      case (op)
        OPC_HALT: r.status = ST_STOPPED;
        OPC_PUSH: begin
          if (stk_ptr >= STACK_DEPTH) begin
            r.status = ST_OVERFLOW;
          end else begin
            stk_mem[stk_ptr] = WORD_W'(imm);
            stk_ptr++;
          end
        end
        OPC_POP: begin
          if (stk_ptr < 1) r.status = ST_UNDERFLOW;
          else stk_ptr--;
        end
        OPC_ADD: begin
          if (stk_ptr < 2) begin
            r.status = ST_UNDERFLOW;
          end else begin
            stk_mem[stk_ptr-2] = stk_mem[stk_ptr-2] + stk_mem[stk_ptr-1];
            stk_ptr--;
          end
        end
        OPC_SYSCALL: begin
          if (stk_ptr < 1) begin
            r.status = ST_UNDERFLOW;
          end else begin
            sel = stk_mem[stk_ptr-1][CHAR_W-1:0];
            if ((sel == SYS_WR_INT || sel == SYS_WR_CHAR) && stk_ptr < 2) begin
              r.status = ST_UNDERFLOW;
            end else begin
              case (sel)
                SYS_WR_INT: begin
                  r.kind  = KIND_INT;
                  r.value = stk_mem[stk_ptr-2];
                  stk_ptr -= 2;
                end
                SYS_WR_CHAR: begin
                  r.kind  = KIND_CHAR;
                  r.value = WORD_W'(stk_mem[stk_ptr-2][CHAR_W-1:0]);
                  stk_ptr -= 2;
                end
                SYS_RD_INT:  stk_mem[stk_ptr-1] = rd;
                SYS_RD_CHAR: stk_mem[stk_ptr-1] = WORD_W'(rd[CHAR_W-1:0]);
                default:     r.status = ST_UNKNOWN;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
    if (r.status != ST_OK) halted = 1'b1;
    return r;
  endfunction

  function automatic bit syscall_safe();
    logic [CHAR_W-1:0] sel;
    if (stk_ptr < 1) return 1'b0;
    sel = stk_mem[stk_ptr-1][CHAR_W-1:0];
    if (sel == SYS_RD_INT || sel == SYS_RD_CHAR) return 1'b1;
    return (sel == SYS_WR_INT || sel == SYS_WR_CHAR) && stk_ptr >= 2;
  endfunction

  // Chooses an instruction that keeps the machine running. The stack alternates between
  // climbing toward full and draining toward empty so that every depth is visited.
  function automatic void pick_instr(output logic [OPC_W-1:0] op,
                                     output logic [IMM_W-1:0] imm,
                                     output logic [WORD_W-1:0] rd);
    int roll;
    roll = $urandom_range(0, 99);
    if (stk_ptr == STACK_DEPTH) climbing = 1'b0;
    else if (stk_ptr < 3) climbing = 1'b1;
    imm = IMM_W'($urandom);
    case ($urandom_range(0, 4))
      0:       rd = W_MIN;
      1:       rd = W_MAX;
      2:       rd = W_ZERO;
      3:       rd = W_ONES;
      default: rd = {$urandom, $urandom};
    endcase
    if (roll < 4) begin
      op = OPC_W'($urandom_range(OPC_RSVD5, OPC_RSVD7));
    end else if (stk_ptr < STACK_DEPTH && (stk_ptr == 0 || roll < (climbing ? 85 : 20))) begin
      op = OPC_PUSH;
      // Half of the pushes place a valid selector so that syscalls follow often.
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       imm = SYS_WR_INT;
          1:       imm = SYS_WR_CHAR;
          2:       imm = SYS_RD_INT;
          default: imm = SYS_RD_CHAR;
        endcase
      end
    end else if (syscall_safe() && $urandom_range(0, 1)) begin
      op = OPC_SYSCALL;
    end else if (stk_ptr >= 2 && $urandom_range(0, 1)) begin
      op = OPC_ADD;
    end else begin
      op = OPC_POP;
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  // Offers one instruction, and once the transaction completes records what it should yield.
  task automatic issue(input logic [OPC_W-1:0] op, input logic [IMM_W-1:0] imm,
                       input logic [WORD_W-1:0] rd, input bit from_table = FROM_MODEL,
                       input result_t table_res = R_OK);
    result_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.immediate  <= imm;
    in_ch.read_value <= rd;
    do @(posedge clk); while (!in_ch.ready);
    r = exec_instr(op, imm, rd);
    awaited_results.push_back(from_table ? table_res : r);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Result acceptor: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_kind, out_ch.out_value, out_ch.status};
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("unexpected result: kind=%0d value=%h status=%0d",
                               got.kind, got.value, got.status));
      end else begin
        want = awaited_results.pop_front();
        if (got.kind !== want.kind || got.value !== want.value || got.status !== want.status)
          note_failure($sformatf({"result mismatch: expected kind=%0d value=%h status=%0d,",
                                  " got kind=%0d value=%h status=%0d"},
                                 want.kind, want.value, want.status,
                                 got.kind, got.value, got.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** stack_machine_executor_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [OPC_W-1:0]  op;
    logic [IMM_W-1:0]  imm;
    logic [WORD_W-1:0] rd;
    logic [CHAR_W-1:0] bad_sel;
    end_kind_t         end_kind;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OPC_HALT;
    in_ch.immediate  = '0;
    in_ch.read_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      issue(dir_rows[i].op, dir_rows[i].imm, dir_rows[i].rd,
            dir_rows[i].from_table, dir_rows[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_drained();
        tx_idle_pct = 87;
        rx_idle_pct = 16;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        // Full rate from here on; the acceptor first stalls long enough to back up the input.
        wait_drained();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
      end
      pick_instr(op, imm, rd);
      issue(op, imm, rd);
    end

    // Only one stopping event is possible per reset; the seed picks which one.
    end_kind = end_kind_t'($urandom_range(0, 3));
    case (end_kind)
      END_HALT: issue(OPC_HALT, IMM_W'($urandom), W_ONES);
      END_OVERFLOW: begin
        while (stk_ptr < STACK_DEPTH) issue(OPC_PUSH, IMM_W'($urandom), W_ZERO);
        issue(OPC_PUSH, IMM_W'($urandom), W_ZERO);
      end
      END_UNDERFLOW: begin
        while (stk_ptr > 0) issue(OPC_POP, IMM_W'($urandom), W_ZERO);
        case ($urandom_range(0, 3))
          0: issue(OPC_POP, IMM_W'($urandom), W_ZERO);
          1: issue(OPC_SYSCALL, IMM_W'($urandom), W_ZERO);
          2: begin
            issue(OPC_PUSH, $urandom_range(0, 1) ? SYS_WR_INT : SYS_WR_CHAR, W_ZERO);
            issue(OPC_SYSCALL, IMM_W'($urandom), W_ZERO);
          end
          default: begin
            issue(OPC_PUSH, IMM_W'($urandom), W_ZERO);
            issue(OPC_ADD, IMM_W'($urandom), W_ZERO);
          end
        endcase
      end
      default: begin
        if (stk_ptr == STACK_DEPTH) issue(OPC_POP, IMM_W'($urandom), W_ZERO);
        do bad_sel = CHAR_W'($urandom);
        while (bad_sel == SYS_WR_INT || bad_sel == SYS_WR_CHAR ||
               bad_sel == SYS_RD_INT || bad_sel == SYS_RD_CHAR);
        issue(OPC_PUSH, bad_sel, W_ZERO);
        issue(OPC_SYSCALL, IMM_W'($urandom), W_ZERO);
      end
    endcase

    // A stopped machine must answer everything with the stopped status.
    repeat (STOPPED_ITEMS)
      issue(OPC_W'($urandom_range(0, 7)), IMM_W'($urandom), {$urandom, $urandom});

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** stack_machine_executor_unit: PASSED **");
    end else begin
      $display("** stack_machine_executor_unit: FAILED **");
    end
    $finish;
  end

endmodule
